/* rtl/rsl_pkg.sv */
`timescale 1ns / 1ps

package rsl_pkg;

    localparam int MaxDelim = 16;
    localparam int WinDepth = MaxDelim + 2;
    localparam int DlenW    = $clog2(MaxDelim + 1);
    localparam int FillW    = $clog2(WinDepth + 1);
    localparam int PosW     = 32;
    localparam int ValueW   = 32;

    localparam logic [7:0] ChR      = 8'h52;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;

    localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_R,
        PH_QUOTE,
        PH_DELIM,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_RAW,
        ST_BAD_DELIM,
        ST_UNTERMINATED
    } status_t;

    // letters, digits and the allowed punctuation
    function automatic logic is_dchar(input logic [7:0] b);
        logic ok;
        ok = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
            || ((b >= 8'h30) && (b <= 8'h39));
        case (b)
            8'h21, 8'h22, 8'h23, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2C,
            8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
            8'h5B, 8'h5D, 8'h5E, 8'h5F, 8'h7B, 8'h7C, 8'h7D, 8'h7E:
                ok = 1'b1;
            default:
                ok = ok;
        endcase
        return ok;
    endfunction

endpackage

/* rtl/rsl_in_if.sv */
`timescale 1ns / 1ps

interface rsl_in_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic        has_byte;
    logic [7:0]  data_byte;
    logic [31:0] start_offset;

    modport source (output valid, output start_req, output has_byte, output data_byte,
                    output start_offset, input ready);
    modport sink (input valid, input start_req, input has_byte, input data_byte,
                  input start_offset, output ready);
endinterface

/* rtl/rsl_out_if.sv */
`timescale 1ns / 1ps

interface rsl_out_if;
    logic                   valid;
    logic                   ready;
    rsl_pkg::status_t       status;
    logic [rsl_pkg::ValueW-1:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink (input valid, input status, input value, output ready);
endinterface

/* rtl/raw_string_literal_scanner.sv */
`timescale 1ns / 1ps
// a transfer reaches its result via the input register and then the result register
// one byte per cycle unless stalled, set by the scan state update and window compare
// a pending result that is not taken stalls only an item that itself produces a result
// reset (rst_n, async, active low): scanner idle, counters cleared, no result pending
// delimiter and window bytes are not reset; only written entries are ever compared

module raw_string_literal_scanner (
    input logic clk,
    input logic rst_n,
    rsl_in_if.sink    in_ch,
    rsl_out_if.source out_ch
);

    // input register
    logic        in_valid_reg;
    logic        start_req_reg;
    logic        has_byte_reg;
    logic [7:0]  data_byte_reg;
    logic [31:0] start_offset_reg;

    // scan state
    rsl_pkg::phase_t                 phase_reg, phase_next;
    logic [rsl_pkg::DlenW-1:0]       dlen_reg, dlen_next;
    logic [rsl_pkg::FillW-1:0]       fill_reg, fill_next;
    logic [rsl_pkg::PosW-1:0]        count_reg, count_next;
    logic [rsl_pkg::PosW-1:0]        base_reg, base_next;
    // delimiter kept newest-first so the compare is at fixed taps
    logic [7:0] dstore_reg [rsl_pkg::MaxDelim];
    // body history, entry 0 is the most recent byte
    logic [7:0] hist_reg [rsl_pkg::WinDepth];

    // result register
    logic                        out_valid_reg;
    rsl_pkg::status_t            status_reg;
    logic [rsl_pkg::ValueW-1:0]  value_reg;

    // combinational scan step
    rsl_pkg::phase_t             e_phase;
    logic [rsl_pkg::DlenW-1:0]   e_dlen;
    logic [rsl_pkg::FillW-1:0]   e_fill;
    logic [rsl_pkg::PosW-1:0]    e_count;
    logic [rsl_pkg::PosW-1:0]    e_base;
    logic [rsl_pkg::PosW:0]      here_sum;
    logic [rsl_pkg::PosW-1:0]    here;
    logic [rsl_pkg::PosW-1:0]    count_inc;
    logic                        emit;
    rsl_pkg::status_t            res_status;
    logic [rsl_pkg::ValueW-1:0]  res_value;
    logic                        dpush;
    logic                        hpush;
    logic                        incr;
    logic                        closes;
    logic                        taps_ok;
    logic                        stall;
    logic                        advance;

    assign e_phase = start_req_reg ? rsl_pkg::PH_R : phase_reg;
    assign e_dlen  = start_req_reg ? '0 : dlen_reg;
    assign e_fill  = start_req_reg ? '0 : fill_reg;
    assign e_count = start_req_reg ? '0 : count_reg;
    assign e_base  = start_req_reg ? start_offset_reg[rsl_pkg::PosW-1:0] : base_reg;

    // absolute position of the current byte, saturating
    assign here_sum  = {1'b0, e_base} + {1'b0, e_count};
    assign here      = here_sum[rsl_pkg::PosW] ? rsl_pkg::PosMax : here_sum[rsl_pkg::PosW-1:0];
    assign count_inc = (e_count == rsl_pkg::PosMax) ? rsl_pkg::PosMax
                                                    : e_count + {{(rsl_pkg::PosW-1){1'b0}}, 1'b1};

    // closing sequence: quote now, delimiter reversed behind it, close paren at depth dlen+1
    always_comb
    begin
        taps_ok = 1'b1;
        for (int k = 0; k < rsl_pkg::MaxDelim; k++)
        begin
            if ((k < int'(e_dlen)) && (hist_reg[k] != dstore_reg[k]))
            begin
                taps_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_next = e_phase;
        dlen_next  = e_dlen;
        fill_next  = e_fill;
        base_next  = e_base;
        emit       = 1'b0;
        res_status = rsl_pkg::ST_OK;
        res_value  = '0;
        dpush      = 1'b0;
        hpush      = 1'b0;
        incr       = 1'b0;
        closes     = 1'b0;
        unique case (e_phase)
            rsl_pkg::PH_IDLE, rsl_pkg::PH_DONE:
            begin
                // bytes outside a scan are dropped
            end
            rsl_pkg::PH_R:
            begin
                if (!has_byte_reg || (data_byte_reg != rsl_pkg::ChR))
                begin
                    emit       = 1'b1;
                    res_status = rsl_pkg::ST_NOT_RAW;
                    res_value  = e_base[rsl_pkg::ValueW-1:0];
                    phase_next = rsl_pkg::PH_DONE;
                end
                else
                begin
                    phase_next = rsl_pkg::PH_QUOTE;
                    incr       = 1'b1;
                end
            end
            rsl_pkg::PH_QUOTE:
            begin
                if (!has_byte_reg || (data_byte_reg != rsl_pkg::ChQuote))
                begin
                    emit       = 1'b1;
                    res_status = rsl_pkg::ST_NOT_RAW;
                    res_value  = e_base[rsl_pkg::ValueW-1:0];
                    phase_next = rsl_pkg::PH_DONE;
                end
                else
                begin
                    phase_next = rsl_pkg::PH_DELIM;
                    incr       = 1'b1;
                end
            end
            rsl_pkg::PH_DELIM:
            begin
                if (!has_byte_reg)
                begin
                    emit       = 1'b1;
                    res_status = rsl_pkg::ST_UNTERMINATED;
                    res_value  = e_base[rsl_pkg::ValueW-1:0];
                    phase_next = rsl_pkg::PH_DONE;
                end
                else if (data_byte_reg == rsl_pkg::ChLParen)
                begin
                    fill_next  = '0;
                    phase_next = rsl_pkg::PH_BODY;
                    incr       = 1'b1;
                end
                else if (!rsl_pkg::is_dchar(data_byte_reg)
                         || (e_dlen >= rsl_pkg::DlenW'(rsl_pkg::MaxDelim)))
                begin
                    emit       = 1'b1;
                    res_status = rsl_pkg::ST_BAD_DELIM;
                    res_value  = here[rsl_pkg::ValueW-1:0];
                    phase_next = rsl_pkg::PH_DONE;
                end
                else
                begin
                    dpush     = 1'b1;
                    dlen_next = e_dlen + {{(rsl_pkg::DlenW-1){1'b0}}, 1'b1};
                    incr      = 1'b1;
                end
            end
            rsl_pkg::PH_BODY:
            begin
                if (!has_byte_reg)
                begin
                    emit       = 1'b1;
                    res_status = rsl_pkg::ST_UNTERMINATED;
                    res_value  = e_base[rsl_pkg::ValueW-1:0];
                    phase_next = rsl_pkg::PH_DONE;
                end
                else
                begin
                    hpush = 1'b1;
                    if (e_fill < rsl_pkg::FillW'(rsl_pkg::WinDepth))
                    begin
                        fill_next = e_fill + {{(rsl_pkg::FillW-1){1'b0}}, 1'b1};
                    end
                    closes = (data_byte_reg == rsl_pkg::ChQuote)
                          && ({1'b0, fill_next} >= ({1'b0, e_dlen} + (rsl_pkg::FillW+1)'(2)))
                          && (hist_reg[e_dlen] == rsl_pkg::ChRParen)
                          && taps_ok;
                    if (closes)
                    begin
                        emit       = 1'b1;
                        res_status = rsl_pkg::ST_OK;
                        res_value  = count_inc[rsl_pkg::ValueW-1:0];
                        phase_next = rsl_pkg::PH_DONE;
                    end
                    else
                    begin
                        incr = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = rsl_pkg::PH_IDLE;
            end
        endcase
        count_next = incr ? count_inc : e_count;
    end

    // an item with a result waits only while the result register is still full
    assign stall   = emit && out_valid_reg && !out_ch.ready;
    assign advance = in_valid_reg && !stall;

    assign in_ch.ready   = !in_valid_reg || advance;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.value  = value_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= rsl_pkg::PH_IDLE;
            dlen_reg      <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            base_reg      <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg <= phase_next;
                dlen_reg  <= dlen_next;
                fill_reg  <= fill_next;
                count_reg <= count_next;
                base_reg  <= base_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            start_req_reg    <= in_ch.start_req;
            has_byte_reg     <= in_ch.has_byte;
            data_byte_reg    <= in_ch.data_byte;
            start_offset_reg <= in_ch.start_offset;
        end
        if (advance && emit)
        begin
            status_reg <= res_status;
            value_reg  <= res_value;
        end
        if (advance && dpush)
        begin
            dstore_reg[0] <= data_byte_reg;
            for (int k = 1; k < rsl_pkg::MaxDelim; k++)
            begin
                dstore_reg[k] <= dstore_reg[k-1];
            end
        end
        if (advance && hpush)
        begin
            hist_reg[0] <= data_byte_reg;
            for (int k = 1; k < rsl_pkg::WinDepth; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_valid_reg)
        else $error("result not loaded into the result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !(advance && emit))
        else $error("pending result overwritten");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(data_byte_reg)))
        else $error("stalled item lost");

    a_dlen_range: assert property (@(posedge clk) disable iff (!rst_n)
        dlen_reg <= rsl_pkg::DlenW'(rsl_pkg::MaxDelim))
        else $error("delimiter length out of range");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= rsl_pkg::FillW'(rsl_pkg::WinDepth))
        else $error("window fill out of range");
`endif

endmodule
